@@ src/assert_macros.svh @@
// assertion macros shared by the cache tag block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, masked while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/salc_pkg.sv @@
// constants, types and address helpers for the set associative lru cache tags
package salc_pkg;

  // geometry, each a power of two
  localparam int LINE_BYTES = 64;
  localparam int SETS       = 64;
  localparam int WAYS       = 8;

  localparam int ADDR_W = 32;
  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int TAG_W  = ADDR_W - OFF_W - $clog2(SETS);
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W  = WAY_W;

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

  // one set worth of tag state
  typedef struct packed {
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0][AGE_W-1:0]  age;
    logic [WAYS-1:0][TAG_W-1:0]  tag;
  } row_t;

  // row write request toward the tag store
  typedef struct packed {
    logic              en;
    logic [SET_W-1:0]  set;
    row_t              row;
  } wr_req_t;

  // outcome of one lookup
  typedef struct packed {
    logic             hit;
    logic [WAYS-1:0]  pick_oh;
    row_t             row;
  } lru_res_t;

  function automatic logic [SET_W-1:0] addr_set(input logic [ADDR_W-1:0] addr);
    return SET_W'((addr / LINE_BYTES) % SETS);
  endfunction

  function automatic logic [TAG_W-1:0] addr_tag(input logic [ADDR_W-1:0] addr);
    return TAG_W'(addr / (LINE_BYTES * SETS));
  endfunction

endpackage

@@ src/salc_if.sv @@
// valid/ready channel interfaces for the address input and the hit result
interface salc_in_if;
  logic                          valid;
  logic                          ready;
  logic [salc_pkg::ADDR_W-1:0]   address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface salc_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, output hit, input ready);
  modport sink   (input valid, input hit, output ready);
endinterface

@@ src/set_associative_lru_cache_tags.sv @@
// top level of the tag-only set associative cache with true lru aging
//
// in_ch carries one byte address per transfer, out_ch one hit flag per
// address, in the same order
// the line offset is dropped, the next bits pick the set, the rest is the tag
// a hit makes its way youngest; a miss fills the lowest empty way or evicts
// the lowest-numbered oldest way, aging the other valid ways of the set
// the transfer edge registers the tag store read and the lookup stage; compare
// and update are combinational and load the result register as the stage advances
// throughput: one address per cycle unless out_ch stalls, set by the single
// read and single write port of the tag store; a same-set address in the next
// cycle takes the just-updated row from a forwarding register
// reset clears every row flag, so all ways read empty with age zero at once;
// no clearing pass is needed and the first address is taken right after reset
// when out_ch stalls the result waits in the output register, one more
// address waits in the lookup stage, and in_ch.ready drops only then
module set_associative_lru_cache_tags (
  input  logic        clk,
  input  logic        rst_n,
  salc_in_if.sink     in_ch,
  salc_out_if.source  out_ch
);

  `include "assert_macros.svh"

  // lookup stage
  logic                         s1_valid_r;
  logic [salc_pkg::SET_W-1:0]   s1_set_r;
  logic [salc_pkg::TAG_W-1:0]   s1_tag_r;

  // result register
  logic                         out_valid_r;
  logic                         out_hit_r;

  logic                         in_fire;
  logic                         s1_adv;
  salc_pkg::row_t               cur_row;
  salc_pkg::lru_res_t           upd;
  salc_pkg::wr_req_t            wr;

  // lookup stage moves on whenever the result register is free or draining
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // updated row goes back to the store as the result leaves the stage
  assign wr.en  = s1_adv;
  assign wr.set = s1_set_r;
  assign wr.row = upd.row;

  salc_tag_ram u_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_fire),
    .rd_set (salc_pkg::addr_set(in_ch.address)),
    .wr     (wr),
    .rd_row (cur_row)
  );

  salc_lru_update u_upd (
    .cur (cur_row),
    .tag (s1_tag_r),
    .res (upd)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_set_r <= salc_pkg::addr_set(in_ch.address);
      s1_tag_r <= salc_pkg::addr_tag(in_ch.address);
    end
    if (s1_adv) begin
      out_hit_r <= upd.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = out_hit_r;

  // a blocked lookup keeps its set and stays pending
  `ASSERT_CLK(a_s1_hold, (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_set_r)), "blocked lookup lost its item")
  // every lookup that leaves lands in the result register
  `ASSERT_CLK(a_adv_out, s1_adv |=> out_valid_r, "lookup left without a result")
  // exactly one way is chosen per lookup
  `ASSERT_CLK(a_pick_onehot, s1_valid_r |-> $onehot(upd.pick_oh), "way choice not one-hot")
  // the chosen way is valid after the update, hit or fill
  `ASSERT_CLK(a_pick_valid, s1_valid_r |-> ((upd.row.valid & upd.pick_oh) == upd.pick_oh), "chosen way left invalid")
  // nothing is offered straight out of reset
  `ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid_r, "result offered after reset")

endmodule

@@ src/salc_tag_ram.sv @@
// per-set tag store with row valid flags and same-set write forwarding
module salc_tag_ram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [salc_pkg::SET_W-1:0]    rd_set,
  input  salc_pkg::wr_req_t             wr,
  output salc_pkg::row_t                rd_row
);

  salc_pkg::row_t          mem [salc_pkg::SETS];
  logic [salc_pkg::SETS-1:0] row_vld_r;
  salc_pkg::row_t          rdata_r;
  salc_pkg::row_t          fwd_row_r;
  logic                    rv_r;
  logic                    fwd_r;

  // storage, read data registered
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.set] <= wr.row;
    end
    if (rd_en) begin
      rdata_r   <= mem[rd_set];
      fwd_row_r <= wr.row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rv_r      <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      if (wr.en) begin
        row_vld_r[wr.set] <= 1'b1;
      end
      if (rd_en) begin
        rv_r  <= row_vld_r[rd_set];
        fwd_r <= wr.en && (wr.set == rd_set);
      end
    end
  end

  // a row never written reads as all ways empty with age zero
  assign rd_row = fwd_r ? fwd_row_r : (rv_r ? rdata_r : '0);

endmodule

@@ src/salc_lru_update.sv @@
// way compare, victim choice and age update for one set
module salc_lru_update (
  input  salc_pkg::row_t              cur,
  input  logic [salc_pkg::TAG_W-1:0]  tag,
  output salc_pkg::lru_res_t          res
);

  always_comb begin
    logic [salc_pkg::WAYS-1:0]   match;
    logic [salc_pkg::WAY_W-1:0]  hit_idx;
    logic [salc_pkg::WAY_W-1:0]  fill_idx;
    logic [salc_pkg::WAY_W-1:0]  vic_idx;
    logic [salc_pkg::WAY_W-1:0]  pick;
    logic [salc_pkg::AGE_W-1:0]  max_age;
    logic [salc_pkg::AGE_W-1:0]  limit;
    logic                        any_hit;
    logic                        any_inv;
    logic                        age_all;

    for (int w = 0; w < salc_pkg::WAYS; w++) begin
      match[w] = cur.valid[w] && (cur.tag[w] == tag);
    end
    any_hit = |match;
    any_inv = ~&cur.valid;

    // lowest-numbered matching and empty ways
    hit_idx  = '0;
    fill_idx = '0;
    for (int w = salc_pkg::WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_idx = salc_pkg::WAY_W'(w);
      end
      if (!cur.valid[w]) begin
        fill_idx = salc_pkg::WAY_W'(w);
      end
    end

    // oldest way, lowest index on a tie
    max_age = cur.age[0];
    vic_idx = '0;
    for (int w = 1; w < salc_pkg::WAYS; w++) begin
      if (cur.age[w] > max_age) begin
        max_age = cur.age[w];
        vic_idx = salc_pkg::WAY_W'(w);
      end
    end

    if (any_hit) begin
      pick    = hit_idx;
      limit   = cur.age[hit_idx];
      age_all = 1'b0;
    end else if (any_inv) begin
      pick    = fill_idx;
      limit   = max_age;
      age_all = 1'b1;
    end else begin
      pick    = vic_idx;
      limit   = max_age;
      age_all = 1'b0;
    end

    res.row = cur;
    for (int w = 0; w < salc_pkg::WAYS; w++) begin
      res.pick_oh[w] = (salc_pkg::WAY_W'(w) == pick);
      if (!res.pick_oh[w] && cur.valid[w] && (age_all || (cur.age[w] < limit)) &&
          (cur.age[w] < salc_pkg::AGE_MAX)) begin
        res.row.age[w] = cur.age[w] + salc_pkg::AGE_W'(1);
      end
    end
    res.row.age[pick] = '0;
    if (!any_hit) begin
      res.row.valid[pick] = 1'b1;
      res.row.tag[pick]   = tag;
    end
    res.hit = any_hit;
  end

endmodule

@@ sim/cache_tag_checker.sv @@
// checker for the cache tag block: lru prediction of every address and hit comparison
module cache_tag_checker
  import salc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  salc_in_if    in_ch,
  salc_out_if   out_ch,
  output int    fail_count,
  output int    pending,
  output int    hit_count,
  output int    fill_count,
  output int    evict_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_BITS = $clog2(SETS);

  typedef enum logic [1:0] {ACC_HIT, ACC_FILL, ACC_EVICT} access_kind_e;

  // shadow of the tag store
  bit               line_valid [SETS][WAYS];
  logic [TAG_W-1:0] line_tag   [SETS][WAYS];
  logic [AGE_W-1:0] line_age   [SETS][WAYS];

  bit expected_hit_q [$];

  // ages every other valid way below limit, saturating, and makes pick youngest
  function automatic void age_set(input int s, input int pick, input int limit);
    for (int w = 0; w < WAYS; w++) begin
      if (w != pick && line_valid[s][w] && int'(line_age[s][w]) < limit &&
          line_age[s][w] != AGE_MAX)
        line_age[s][w] = line_age[s][w] + 1'b1;
    end
    line_age[s][pick] = '0;
  endfunction

  function automatic access_kind_e predict_access(input logic [ADDR_W-1:0] addr);
    int               s;
    logic [TAG_W-1:0] t;
    int               victim;
    int               oldest;
    s = int'((addr >> OFF_W) % SETS);
    t = TAG_W'(addr >> (OFF_W + SET_BITS));
    for (int w = 0; w < WAYS; w++) begin
      if (line_valid[s][w] && line_tag[s][w] == t) begin
        age_set(s, w, int'(line_age[s][w]));
        return ACC_HIT;
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!line_valid[s][w]) begin
        age_set(s, w, WAYS + 1);
        line_valid[s][w] = 1'b1;
        line_tag[s][w]   = t;
        return ACC_FILL;
      end
    end
    victim = 0;
    oldest = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (int'(line_age[s][w]) > oldest) begin
        oldest = int'(line_age[s][w]);
        victim = w;
      end
    end
    line_tag[s][victim] = t;
    age_set(s, victim, oldest);
    return ACC_EVICT;
  endfunction

  always @(posedge clk) begin : watch
    access_kind_e kind;
    bit           want;
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          line_valid[s][w] = 1'b0;
          line_age[s][w]   = '0;
          line_tag[s][w]   = '0;
        end
      end
      expected_hit_q.delete();
      pending <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        kind = predict_access(in_ch.address);
        expected_hit_q.push_back(kind == ACC_HIT);
        case (kind)
          ACC_HIT:  hit_count   <= hit_count + 1;
          ACC_FILL: fill_count  <= fill_count + 1;
          default:  evict_count <= evict_count + 1;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hit_q.size() == 0) begin
          $error("unexpected result transfer, hit %0b", out_ch.hit);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_hit_q.pop_front();
          if (out_ch.hit !== want) begin
            $error("hit mismatch: expected %0b, actual %0b", want, out_ch.hit);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_hit_q.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
// testbench top for the cache tag block: clock, reset, address stimulus and verdict
module tb_top;
  import salc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_BITS     = $clog2(SETS);
  localparam int RANDOM_ITEMS = 600;
  localparam int QUIET_LIMIT  = 5000;  // cycles with no transfer before giving up
  localparam int HOLD_CYCLES  = 40;    // long receiver hold-off

  logic clk;
  logic rst_n;

  salc_in_if  in_ch();
  salc_out_if out_ch();

  int fail_count;
  int pending;
  int hit_count;
  int fill_count;
  int evict_count;

  int results_seen;
  int quiet_cycles;
  bit calm;  // both sides stop idling while set

  set_associative_lru_cache_tags dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cache_tag_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .hit_count   (hit_count),
    .fill_count  (fill_count),
    .evict_count (evict_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // reset held low from the start, released on a falling edge
  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // count result transfers, and bail out when the channels go quiet for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        results_seen <= results_seen + 1;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results still due",
                 QUIET_LIMIT, pending);
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side: random back-pressure, one long hold-off once traffic is flowing
  initial begin : result_sink
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 120) begin
        // hold off while the sender keeps offering, so the pipe fills and in_ch stalls
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else if (calm) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // byte address from tag, set index and line offset
  function automatic logic [ADDR_W-1:0] line_addr(input logic [TAG_W-1:0] tag,
                                                  input int set_idx, input int offset);
    return (ADDR_W'(tag) << (OFF_W + SET_BITS)) |
           (ADDR_W'(set_idx % SETS) << OFF_W) |
           ADDR_W'(offset % LINE_BYTES);
  endfunction

  // one address transfer; called on a falling edge, returns on a falling edge
  task automatic send_addr(input logic [ADDR_W-1:0] addr);
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.address = addr;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  initial begin : addr_source
    logic [TAG_W-1:0] tag_pool [11];
    int               hot_sets [4];
    int               roll;
    logic [ADDR_W-1:0] addr;

    calm          = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.address = '0;
    wait (rst_n);
    @(negedge clk);

    // directed: address extremes, same-line offsets, fill a set, evict, hit on old ways
    send_addr('0);                                  // miss, set 0
    send_addr(ADDR_W'(LINE_BYTES - 1));             // same line, other offset: hit
    send_addr('1);                                  // miss, all-ones tag in last set
    send_addr(~ADDR_W'(LINE_BYTES - 1));            // same line: hit
    send_addr(ADDR_W'(1) << (ADDR_W - 1));          // top tag bit alone
    for (int k = 1; k <= WAYS; k++)
      send_addr(line_addr(TAG_W'(k), 5, k * 7));    // fills every empty way of set 5
    send_addr(line_addr(TAG_W'(WAYS + 1), 5, 0));   // full set: evicts the oldest
    send_addr(line_addr(TAG_W'(3), 5, 63));         // hit on the second-oldest way
    send_addr(line_addr(TAG_W'(1), 5, 1));          // evicted tag misses again
    send_addr(line_addr('0, 1, 0));                 // neighbor set
    send_addr(line_addr(TAG_W'(WAYS + 1), 5, 9));   // hit on the third-youngest way
    send_addr(line_addr(TAG_W'(3), 5, 2));          // back-to-back hit, other way of the same set

    // random: a few hot sets and a tag pool a bit larger than the ways,
    // so hits, fills and evictions mix; some fully random addresses on top
    for (int k = 0; k < 11; k++)
      tag_pool[k] = TAG_W'($urandom);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) begin
        for (int k = 0; k < 4; k++)
          hot_sets[k] = $urandom_range(0, SETS - 1);
        tag_pool[$urandom_range(0, 10)] = TAG_W'($urandom);
      end
      calm = (i >= 250 && i < 400);
      if (i == 450) begin
        // drain completely before going on
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      roll = $urandom_range(0, 99);
      if (roll < 15)
        addr = $urandom;
      else
        addr = line_addr(tag_pool[$urandom_range(0, 10)], hot_sets[$urandom_range(0, 3)],
                         $urandom_range(0, LINE_BYTES - 1));
      send_addr(addr);
    end
    in_ch.valid = 1'b0;
    calm        = 1'b0;

    // wait for the last results, then idle on a little for any stray transfer
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d addresses: %0d hits, %0d fills of empty ways, %0d evictions",
             hit_count + fill_count + evict_count, hit_count, fill_count, evict_count);
    $display("random part used hot sets with a small tag pool, one long result hold-off");
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
